/* sv/hsv2rgb_pkg.sv */
// shared types and constants for the hsv to rgb converter
package hsv2rgb_pkg;

   // one sector is 60 degrees at 1/64 degree per hue step
   localparam logic [14:0] SECTOR_UNITS = 15'd3840;
   localparam logic [14:0] TWO_SECTORS  = 15'd7680;

   // hue thresholds for the sector boundaries
   localparam logic [14:0] HUE_SECT_1 = 15'd3840;
   localparam logic [14:0] HUE_SECT_2 = 15'd7680;
   localparam logic [14:0] HUE_SECT_3 = 15'd11520;
   localparam logic [14:0] HUE_SECT_4 = 15'd15360;
   localparam logic [14:0] HUE_SECT_5 = 15'd19200;

   // hue thresholds for folding into one 120 degree span
   localparam logic [14:0] HUE_FOLD_1 = 15'd7680;
   localparam logic [14:0] HUE_FOLD_2 = 15'd15360;
   localparam logic [14:0] HUE_FOLD_3 = 15'd23040;
   localparam logic [14:0] HUE_FOLD_4 = 15'd30720;

   // floor(2^24 / 15), for the divide by 15 after the shift by 256
   localparam logic [20:0] RECIP_15   = 21'd1118481;
   localparam int          RECIP_BITS = 24;

   typedef enum logic [2:0] {
      SECT_RED_YEL = 3'd0,
      SECT_YEL_GRN = 3'd1,
      SECT_GRN_CYN = 3'd2,
      SECT_CYN_BLU = 3'd3,
      SECT_BLU_MAG = 3'd4,
      SECT_MAG_RED = 3'd5
   } sector_type;

   typedef struct packed {
      logic [14:0] hue;
      logic [7:0]  saturation;
      logic [7:0]  brightness;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   typedef struct packed {
      sector_type  sector;
      logic [11:0] weight;
      logic [15:0] chroma;
      logic [7:0]  brightness;
   } front_type;

   typedef struct packed {
      sector_type  sector;
      logic [15:0] chroma;
      logic [15:0] offset;
      logic [15:0] second;
   } mid_type;

endpackage

/* sv/hsv2rgb_front.sv */
// first stage: sector, folded hue weight and chroma product
module hsv2rgb_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  hsv2rgb_pkg::req_type   in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output hsv2rgb_pkg::front_type out_data
);
   import hsv2rgb_pkg::*;

   logic       valid_ff;
   front_type  data_ff;
   front_type  data_in;
   sector_type sector;
   logic [14:0] folded;
   logic [14:0] hue;

   assign hue = in_data.hue;

   always_comb begin
      if (hue >= HUE_SECT_5) begin
         sector = SECT_MAG_RED;
      end else if (hue >= HUE_SECT_4) begin
         sector = SECT_BLU_MAG;
      end else if (hue >= HUE_SECT_3) begin
         sector = SECT_CYN_BLU;
      end else if (hue >= HUE_SECT_2) begin
         sector = SECT_GRN_CYN;
      end else if (hue >= HUE_SECT_1) begin
         sector = SECT_YEL_GRN;
      end else begin
         sector = SECT_RED_YEL;
      end
   end

   // hue mod 7680
   always_comb begin
      if (hue >= HUE_FOLD_4) begin
         folded = hue - HUE_FOLD_4;
      end else if (hue >= HUE_FOLD_3) begin
         folded = hue - HUE_FOLD_3;
      end else if (hue >= HUE_FOLD_2) begin
         folded = hue - HUE_FOLD_2;
      end else if (hue >= HUE_FOLD_1) begin
         folded = hue - HUE_FOLD_1;
      end else begin
         folded = hue;
      end
   end

   always_comb begin
      data_in.sector     = sector;
      data_in.chroma     = 16'(in_data.brightness) * 16'(in_data.saturation);
      data_in.brightness = in_data.brightness;
      if (folded >= SECTOR_UNITS) begin
         data_in.weight = 12'(TWO_SECTORS - folded);
      end else begin
         data_in.weight = 12'(folded);
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

/* sv/hsv2rgb_second.sv */
// stages two to four: secondary term via multiply and reciprocal divide
module hsv2rgb_second (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  hsv2rgb_pkg::front_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output hsv2rgb_pkg::mid_type   out_data
);
   import hsv2rgb_pkg::*;

   // stage a: chroma times weight, offset
   logic        va_ff;
   sector_type  sect_a_ff;
   logic [15:0] chroma_a_ff;
   logic [15:0] offset_a_ff;
   logic [27:0] prod_a_ff;
   // stage b: reciprocal product for the divide by 15
   logic        vb_ff;
   sector_type  sect_b_ff;
   logic [15:0] chroma_b_ff;
   logic [15:0] offset_b_ff;
   logic [19:0] shifted_b_ff;
   logic [15:0] quot_b_ff;
   // stage c: corrected quotient
   logic        vc_ff;
   mid_type     data_c_ff;

   logic        ready_a;
   logic        ready_b;
   logic        ready_c;
   logic [15:0] offset_in;
   logic [19:0] shifted_in;
   logic [40:0] recip_prod;
   logic [19:0] fifteen_q;
   logic [19:0] remain;
   mid_type     data_c_in;

   assign ready_c  = !vc_ff || out_ready;
   assign ready_b  = !vb_ff || ready_c;
   assign ready_a  = !va_ff || ready_b;
   assign in_ready = ready_a;

   assign offset_in  = ({in_data.brightness, 8'h00} - 16'(in_data.brightness)) - in_data.chroma;
   assign shifted_in = prod_a_ff[27:8];
   assign recip_prod = 41'(shifted_in) * 41'(RECIP_15);

   // estimate is exact or one low
   assign fifteen_q = {quot_b_ff, 4'h0} - 20'(quot_b_ff);
   assign remain    = shifted_b_ff - fifteen_q;

   always_comb begin
      data_c_in.sector = sect_b_ff;
      data_c_in.chroma = chroma_b_ff;
      data_c_in.offset = offset_b_ff;
      data_c_in.second = quot_b_ff + 16'(remain >= 20'd15);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (ready_a) begin
            va_ff <= in_valid;
         end
         if (ready_b) begin
            vb_ff <= va_ff;
         end
         if (ready_c) begin
            vc_ff <= vb_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && ready_a) begin
         sect_a_ff   <= in_data.sector;
         chroma_a_ff <= in_data.chroma;
         offset_a_ff <= offset_in;
         prod_a_ff   <= 28'(in_data.chroma) * 28'(in_data.weight);
      end
      if (va_ff && ready_b) begin
         sect_b_ff    <= sect_a_ff;
         chroma_b_ff  <= chroma_a_ff;
         offset_b_ff  <= offset_a_ff;
         shifted_b_ff <= shifted_in;
         quot_b_ff    <= recip_prod[RECIP_BITS+15:RECIP_BITS];
      end
      if (vb_ff && ready_c) begin
         data_c_ff <= data_c_in;
      end
   end

   assign out_valid = vc_ff;
   assign out_data  = data_c_ff;

`ifndef SYNTHESIS
   a_remain_bound: assert property (@(posedge clock) disable iff (reset)
      vb_ff |-> remain < 20'd30)
      else $error("reciprocal estimate off by more than one");

   a_second_bound: assert property (@(posedge clock) disable iff (reset)
      vc_ff |-> data_c_ff.second <= data_c_ff.chroma)
      else $error("secondary term above chroma");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      vc_ff && !out_ready |=> vc_ff && $stable(data_c_ff))
      else $error("last stage changed while stalled");
`endif

endmodule

/* sv/hsv2rgb_mix.sv */
// output stage: route chroma and secondary term, add offset, divide by 255
module hsv2rgb_mix (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hsv2rgb_pkg::mid_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hsv2rgb_pkg::rsp_type out_data
);
   import hsv2rgb_pkg::*;

   logic        valid_ff;
   rsp_type     data_ff;
   rsp_type     data_in;
   logic [15:0] comp_r;
   logic [15:0] comp_g;
   logic [15:0] comp_b;

   // floor(sum / 255) for sums up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] comp, input logic [15:0] offset);
      logic [15:0] sum;
      logic [16:0] t;
      sum = comp + offset;
      t   = 17'(sum) + 17'd1 + 17'(sum[15:8]);
      return t[15:8];
   endfunction

   always_comb begin
      comp_r = 16'h0000;
      comp_g = 16'h0000;
      comp_b = 16'h0000;
      case (in_data.sector)
         SECT_RED_YEL: begin
            comp_r = in_data.chroma;
            comp_g = in_data.second;
         end
         SECT_YEL_GRN: begin
            comp_r = in_data.second;
            comp_g = in_data.chroma;
         end
         SECT_GRN_CYN: begin
            comp_g = in_data.chroma;
            comp_b = in_data.second;
         end
         SECT_CYN_BLU: begin
            comp_g = in_data.second;
            comp_b = in_data.chroma;
         end
         SECT_BLU_MAG: begin
            comp_r = in_data.second;
            comp_b = in_data.chroma;
         end
         default: begin
            comp_r = in_data.chroma;
            comp_b = in_data.second;
         end
      endcase
   end

   always_comb begin
      data_in.red   = div255(comp_r, in_data.offset);
      data_in.green = div255(comp_g, in_data.offset);
      data_in.blue  = div255(comp_b, in_data.offset);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

/* sv/hsv_to_rgb_converter.sv */
// top level: five register stages, from the front stage through the secondary-term stages to the mix stage
// throughput one item per clock while rsp_ready is high; each stage holds under back-pressure and a
// stage with no item takes a new one even while the output item waits
// the widest steps are the chroma-weight multiply and the reciprocal multiply
// reset: synchronous, active high, clears all stage valid bits; no other state
module hsv_to_rgb_converter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hsv2rgb_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hsv2rgb_pkg::rsp_type rsp_data
);
   import hsv2rgb_pkg::*;

   // front to secondary-term stages
   logic      front_valid;
   logic      front_ready;
   front_type front_data;
   // secondary-term stages to output mix
   logic      mid_valid;
   logic      mid_ready;
   mid_type   mid_data;

   // stage 1: sector decode, hue fold, chroma = value * saturation
   hsv2rgb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   // stages 2 to 4: chroma * weight, divide by 3840 as shift plus reciprocal
   hsv2rgb_second u_second (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_data  (mid_data)
   );

   // stage 5: channel routing, offset add, divide by 255 into the output register
   hsv2rgb_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_data   (mid_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // input can only stall when the output holds an item that is not taken
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled with output free");

   // nothing comes out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid right after reset");

   // an idle pipeline accepts an item at once
   a_idle_accept: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input not ready with empty output");
`endif

endmodule

/* tb/hsv_to_rgb_converter_tb.sv */
// self-checking testbench for the hsv to rgb converter pipeline
import hsv2rgb_pkg::*;

// keeps predicted pixels in order and checks each one that leaves the block
class pixel_scoreboard;
   localparam int unsigned FULL_SCALE  = 255;
   localparam int unsigned MAX_REPORTS = 10;

   rsp_type     expected_pixels[$];
   int unsigned error_count;

   function new();
      error_count = 0;
   endfunction

   // integer hsv to rgb in units of 1/65025
   static function rsp_type convert_pixel(req_type pix);
      int unsigned hue, sat, bri;
      int unsigned chroma, folded, distance, second, offset;
      int unsigned rp, gp, bp;
      sector_type  sect;
      rsp_type     rgb;
      hue = pix.hue;
      sat = pix.saturation;
      bri = pix.brightness;
      chroma = bri * sat;
      folded = hue % TWO_SECTORS;
      distance = (folded >= SECTOR_UNITS) ? folded - SECTOR_UNITS : SECTOR_UNITS - folded;
      second = (chroma * (SECTOR_UNITS - distance)) / SECTOR_UNITS;
      offset = bri * FULL_SCALE - chroma;
      // hue past the last boundary, in range or not, lands in magenta to red
      if (hue / SECTOR_UNITS >= int'(SECT_MAG_RED))
         sect = SECT_MAG_RED;
      else
         sect = sector_type'(hue / SECTOR_UNITS);
      rp = 0;
      gp = 0;
      bp = 0;
      case (sect)
         SECT_RED_YEL: begin rp = chroma; gp = second; end
         SECT_YEL_GRN: begin rp = second; gp = chroma; end
         SECT_GRN_CYN: begin gp = chroma; bp = second; end
         SECT_CYN_BLU: begin gp = second; bp = chroma; end
         SECT_BLU_MAG: begin rp = second; bp = chroma; end
         default:      begin rp = chroma; bp = second; end
      endcase
      rgb.red   = 8'((rp + offset) / FULL_SCALE);
      rgb.green = 8'((gp + offset) / FULL_SCALE);
      rgb.blue  = 8'((bp + offset) / FULL_SCALE);
      return rgb;
   endfunction

   function void note_pixel(req_type pix);
      expected_pixels.push_back(convert_pixel(pix));
   endfunction

   function void report(string what, rsp_type want, rsp_type got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%s: expected r %0d g %0d b %0d, got r %0d g %0d b %0d", what,
                  want.red, want.green, want.blue, got.red, got.green, got.blue);
   endfunction

   function void check_pixel(rsp_type got);
      rsp_type want;
      if (expected_pixels.size() == 0) begin
         report("unexpected pixel", '0, got);
         return;
      end
      want = expected_pixels.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
         report("pixel mismatch", want, got);
   endfunction

   function int unsigned pending();
      return expected_pixels.size();
   endfunction
endclass

module hsv_to_rgb_converter_tb;

   localparam int unsigned RANDOM_ITEMS  = 1125;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   // pipeline is five deep, give it spare cycles at the end
   localparam int unsigned DRAIN_CYCLES  = 12;
   // long receiver hold-off so the pipeline fills and pushes back on req_ready
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned MAX_HUE       = 32767;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // idle odds in percent per cycle, changed by the stimulus between phases
   int unsigned send_idle_pct = 12;
   int unsigned recv_idle_pct = 72;

   pixel_scoreboard sb = new();

   hsv_to_rgb_converter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // offer one item, with random idle cycles ahead of it, and wait for accept
   task automatic send_pixel(input logic [14:0] hue, input logic [7:0] sat,
                             input logic [7:0] bri);
      req_type item;
      item = '{hue: hue, saturation: sat, brightness: bri};
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      // ready sampled at the edge is the value the block saw
      while (!req_ready) @(posedge clock);
      sb.note_pixel(item);
   endtask

   // saturation or brightness, leaning on the two extremes
   function automatic logic [7:0] random_level();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // main stimulus and end of run
   initial begin : stimulus
      int unsigned k;
      int          h;
      logic [14:0] hue;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: sector edges, out of range hue, extremes of the levels
      send_pixel(15'd0,     8'd255, 8'd255);
      send_pixel(15'd0,     8'd0,   8'd255);
      send_pixel(15'd0,     8'd255, 8'd0);
      send_pixel(15'd0,     8'd0,   8'd0);
      send_pixel(15'd1920,  8'd255, 8'd255);
      send_pixel(15'd3839,  8'd255, 8'd255);
      send_pixel(15'd3840,  8'd255, 8'd255);
      send_pixel(15'd5760,  8'd128, 8'd200);
      send_pixel(15'd7679,  8'd255, 8'd255);
      send_pixel(15'd7680,  8'd255, 8'd255);
      send_pixel(15'd11519, 8'd255, 8'd255);
      send_pixel(15'd11520, 8'd255, 8'd255);
      send_pixel(15'd15359, 8'd255, 8'd255);
      send_pixel(15'd15360, 8'd255, 8'd255);
      send_pixel(15'd19199, 8'd255, 8'd255);
      send_pixel(15'd19200, 8'd255, 8'd255);
      send_pixel(15'd21120, 8'd77,  8'd191);
      send_pixel(15'd23039, 8'd255, 8'd255);
      // hue past 360 degrees stays in the last sector
      send_pixel(15'd23040, 8'd255, 8'd255);
      send_pixel(15'd26880, 8'd170, 8'd85);
      send_pixel(15'd30720, 8'd255, 8'd255);
      send_pixel(15'd32767, 8'd255, 8'd255);
      send_pixel(15'd32767, 8'd1,   8'd1);
      send_pixel(15'd12345, 8'd1,   8'd254);

      for (k = 0; k < RANDOM_ITEMS; k++) begin
         // idle phases: receiver slow, then sender slow, then full rate
         if (k == RANDOM_ITEMS / 3) begin
            send_idle_pct = 72;
            recv_idle_pct = 12;
         end else if (k == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case ($urandom_range(0, 9))
            0: begin
               // near a sector boundary
               h = int'($urandom_range(0, 8)) * int'(SECTOR_UNITS)
                   + int'($urandom_range(0, 2)) - 1;
               if (h < 0) h = 0;
               if (h > int'(MAX_HUE)) h = int'(MAX_HUE);
               hue = 15'(h);
            end
            1:       hue = 15'($urandom_range(int'(HUE_FOLD_3), MAX_HUE));
            default: hue = 15'($urandom_range(0, int'(HUE_FOLD_3) - 1));
         endcase
         send_pixel(hue, random_level(), random_level());
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0)
         $display("hsv_to_rgb_converter test passed");
      else
         $display("hsv_to_rgb_converter test failed");
      $finish;
   end

   // receiver: checks each accepted pixel, stalls at random and twice for long
   initial begin : receiver
      int unsigned hold_left;
      int unsigned seen;
      hold_left = 0;
      seen      = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_valid && rsp_ready) begin
               sb.check_pixel(rsp_data);
               seen++;
               if (seen == 150 || seen == 800)
                  hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
         end
      end
   end

   // watchdog on total run length
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("hsv_to_rgb_converter test failed");
      $finish;
   end

endmodule
